// ===== rtl/lms_pkg.sv =====
// Shared types and constants for the LED matrix line scanner.
package lms_pkg;

   localparam int COLUMNS_DEFAULT    = 32;
   localparam int HALF_ROWS_DEFAULT  = 16;
   localparam int COLOR_BITS_DEFAULT = 8;

   localparam int BLANK_COLUMN_W = 5;
   localparam logic [BLANK_COLUMN_W-1:0] BLANK_COLUMN_RESET = 5'd23;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_SCAN  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [4:0] pixel_row;
      logic [4:0] pixel_column;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] pwm_level;
      logic [3:0] scan_line;
   } req_payload_type;

   typedef struct packed {
      logic       shift_clock;
      logic       red_top;
      logic       red_bottom;
      logic       green_top;
      logic       green_bottom;
      logic       blue_top;
      logic       blue_bottom;
      logic       latch;
      logic       blank;
      logic [3:0] row_address;
      logic       last;
   } rsp_payload_type;

endpackage

// ===== rtl/lms_req_if.sv =====
// Request channel: valid/ready handshake carrying one pixel write or scan transaction.
interface lms_req_if;
   logic                     valid;
   logic                     ready;
   lms_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lms_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one panel pin state per transaction.
interface lms_rsp_if;
   logic                     valid;
   logic                     ready;
   lms_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/led_matrix_line_scanner_top.sv =====
// LED matrix line scanner: frame store, scan sequencer and panel pin state generator.
//
// Request channel (req_chan): a write transaction stores one RGB pixel into the
// frame store in the cycle it is accepted and returns nothing. A scan transaction
// streams 2*COLUMNS response transactions (64 by default), one per half period of
// the panel shift clock, falling half first; the last one carries last=1.
// Response channel (rsp_chan): one output register. The first pin state of a scan
// passes through the frame store read register and then the output register; a scan
// issues one frame store read per column pair, each issued while the rising half of
// the previous column is loaded.
// The frame store is split into a top-half and a bottom-half memory read at the
// same address, so both rows of a column pair come out in one read.
// A stalled receiver holds the sequencer; no pin state is dropped or repeated.
// The next request is taken while the final pin state still waits in the output.
// Reset: a clearing pass writes black into every frame store entry, one entry per
// cycle; requests wait until it ends. csr_wr_en writes blank_column (reset 23)
// at any time.
module led_matrix_line_scanner_top #(
   parameter int COLUMNS    = lms_pkg::COLUMNS_DEFAULT,
   parameter int HALF_ROWS  = lms_pkg::HALF_ROWS_DEFAULT,
   parameter int COLOR_BITS = lms_pkg::COLOR_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   lms_req_if.sink                            req_chan,
   lms_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [lms_pkg::BLANK_COLUMN_W-1:0] csr_wr_data
);

   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(HALF_ROWS);
   localparam int ADDR_W  = ROW_W + COL_W;
   localparam int WORD_W  = 3 * COLOR_BITS;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int CMP_W   = (COLOR_BITS > 8) ? COLOR_BITS : 8;
   localparam int BC_W    = (COL_W > lms_pkg::BLANK_COLUMN_W) ? COL_W : lms_pkg::BLANK_COLUMN_W;
   localparam int RMOD_STEPS = 4;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   // Frame store halves
   logic [WORD_W-1:0] mem_top [DEPTH];
   logic [WORD_W-1:0] mem_bot [DEPTH];

   state_type                          state_ff, state_in;
   logic [ADDR_W-1:0]                  clear_addr_ff, clear_addr_in;
   logic [COL_W-1:0]                   col_ff, col_in;
   logic                               phase_ff, phase_in;
   logic [ROW_W-1:0]                   top_ff, top_in;
   logic [3:0]                         line_sel_ff, line_sel_in;
   logic [7:0]                         level_ff, level_in;
   logic [lms_pkg::BLANK_COLUMN_W-1:0] blank_column_ff, blank_column_in;
   logic [5:0]                         data_bits_ff, data_bits_in;
   logic                               latch_ff, latch_in;
   logic                               blank_ff, blank_in;
   logic [3:0]                         row_select_ff, row_select_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   lms_pkg::rsp_payload_type           rsp_payload_ff, rsp_payload_in;
   logic [WORD_W-1:0]                  rd_top_ff, rd_bot_ff;

   logic              req_accept;
   logic              out_free;
   logic              mem_we, wr_top_en, wr_bot_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        scan_row;

   function automatic logic [7:0] line_mod(input logic [3:0] line);
      logic [7:0] v;
      v = 8'(line);
      for (int i = 0; i < RMOD_STEPS; i++) begin
         if (v >= 8'(HALF_ROWS)) begin
            v = v - 8'(HALF_ROWS);
         end
      end
      return v;
   endfunction

   function automatic logic [COLOR_BITS-1:0] fit_color(input logic [7:0] c);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(c);
      return ext[COLOR_BITS-1:0];
   endfunction

   function automatic logic above(input logic [COLOR_BITS-1:0] c, input logic [7:0] lvl);
      return CMP_W'(c) > CMP_W'(lvl);
   endfunction

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign scan_row       = line_mod(req_chan.payload.scan_line);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // Frame store write side: clearing pass or pixel write
   always_comb begin
      logic [7:0] prow;
      logic [8:0] pcol;
      logic [7:0] hrow;
      prow      = 8'(req_chan.payload.pixel_row);
      pcol      = 9'(req_chan.payload.pixel_column);
      hrow      = (prow < 8'(HALF_ROWS)) ? prow : prow - 8'(HALF_ROWS);
      wr_top_en = 1'b0;
      wr_bot_en = 1'b0;
      wr_addr   = {hrow[ROW_W-1:0], pcol[COL_W-1:0]};
      wr_data   = {fit_color(req_chan.payload.blue), fit_color(req_chan.payload.green),
                   fit_color(req_chan.payload.red)};
      if (state_ff == ST_CLEAR) begin
         wr_top_en = 1'b1;
         wr_bot_en = 1'b1;
         wr_addr   = clear_addr_ff;
         wr_data   = '0;
      end else if (req_accept && req_chan.payload.kind == lms_pkg::KIND_WRITE
                   && pcol < 9'(COLUMNS)) begin
         wr_top_en = (prow < 8'(HALF_ROWS));
         wr_bot_en = (prow >= 8'(HALF_ROWS)) && (prow < 8'(2 * HALF_ROWS));
      end
      mem_we = wr_top_en || wr_bot_en;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         if (wr_top_en) begin
            mem_top[wr_addr] <= wr_data;
         end
         if (wr_bot_en) begin
            mem_bot[wr_addr] <= wr_data;
         end
      end
      if (rd_en) begin
         rd_top_ff <= mem_top[rd_addr];
         rd_bot_ff <= mem_bot[rd_addr];
      end
   end

   // Scan sequencer
   always_comb begin
      logic [5:0] bits;
      logic       col_last;
      state_in        = state_ff;
      clear_addr_in   = clear_addr_ff;
      col_in          = col_ff;
      phase_in        = phase_ff;
      top_in          = top_ff;
      line_sel_in     = line_sel_ff;
      level_in        = level_ff;
      blank_column_in = csr_wr_en ? csr_wr_data : blank_column_ff;
      data_bits_in    = data_bits_ff;
      latch_in        = latch_ff;
      blank_in        = blank_ff;
      row_select_in   = row_select_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_payload_in  = rsp_payload_ff;
      rd_en           = 1'b0;
      rd_addr         = {top_ff, col_ff + COL_W'(1)};
      col_last        = (col_ff == COL_W'(COLUMNS - 1));

      bits[0] = above(rd_top_ff[COLOR_BITS-1:0], level_ff);
      bits[1] = above(rd_bot_ff[COLOR_BITS-1:0], level_ff);
      bits[2] = above(rd_top_ff[2*COLOR_BITS-1:COLOR_BITS], level_ff);
      bits[3] = above(rd_bot_ff[2*COLOR_BITS-1:COLOR_BITS], level_ff);
      bits[4] = above(rd_top_ff[3*COLOR_BITS-1:2*COLOR_BITS], level_ff);
      bits[5] = above(rd_bot_ff[3*COLOR_BITS-1:2*COLOR_BITS], level_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && req_chan.payload.kind == lms_pkg::KIND_SCAN) begin
               state_in    = ST_SCAN;
               col_in      = '0;
               phase_in    = 1'b0;
               top_in      = scan_row[ROW_W-1:0];
               line_sel_in = scan_row[3:0];
               level_in    = req_chan.payload.pwm_level;
               rd_en       = 1'b1;
               rd_addr     = {scan_row[ROW_W-1:0], COL_W'(0)};
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (!phase_ff) begin
                  // falling half: new column data and strobe levels
                  data_bits_in  = bits;
                  latch_in      = latch_ff;
                  row_select_in = row_select_ff;
                  blank_in      = blank_ff;
                  if (col_last) begin
                     latch_in      = 1'b1;
                     row_select_in = line_sel_ff;
                  end
                  if (BC_W'(col_ff) == BC_W'(blank_column_ff)) begin
                     blank_in = 1'b1;
                  end
                  if (col_ff == '0) begin
                     latch_in = 1'b0;
                     blank_in = 1'b0;
                  end
                  rsp_payload_in = '{shift_clock: 1'b0, red_top: bits[0],
                     red_bottom: bits[1], green_top: bits[2], green_bottom: bits[3],
                     blue_top: bits[4], blue_bottom: bits[5], latch: latch_in,
                     blank: blank_in, row_address: row_select_in, last: 1'b0};
                  phase_in = 1'b1;
               end else begin
                  rsp_payload_in             = rsp_payload_ff;
                  rsp_payload_in.shift_clock = 1'b1;
                  rsp_payload_in.last        = col_last;
                  phase_in                   = 1'b0;
                  if (col_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     // fetch next column pair while the rising half goes out
                     col_in = col_ff + COL_W'(1);
                     rd_en  = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clear_addr_ff   <= '0;
         col_ff          <= '0;
         phase_ff        <= 1'b0;
         blank_column_ff <= lms_pkg::BLANK_COLUMN_RESET;
         data_bits_ff    <= '0;
         latch_ff        <= 1'b0;
         blank_ff        <= 1'b0;
         row_select_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clear_addr_ff   <= clear_addr_in;
         col_ff          <= col_in;
         phase_ff        <= phase_in;
         blank_column_ff <= blank_column_in;
         data_bits_ff    <= data_bits_in;
         latch_ff        <= latch_in;
         blank_ff        <= blank_in;
         row_select_ff   <= row_select_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff         <= top_in;
      line_sel_ff    <= line_sel_in;
      level_ff       <= level_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   a_scan_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.payload.kind == lms_pkg::KIND_SCAN) |=>
         (state_ff == ST_SCAN && !phase_ff && col_ff == '0))
      else $error("scan transaction did not start a falling half");

   a_last_rising: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.last) |-> rsp_chan.payload.shift_clock)
      else $error("last pin state is not a rising half");

   a_no_read_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rd_en && !rsp_chan.valid))
      else $error("frame store read during clearing pass");

   a_latch_col_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && out_free && !phase_ff && col_ff == '0) |=>
         (!rsp_chan.payload.latch && !rsp_chan.payload.blank))
      else $error("latch or blank high at column zero");

endmodule
